/* rtl/crm_pkg.sv */
// Shared types, constants and command structs for the conv/ReLU/max-pool block.
`default_nettype none

package crm_pkg;

  // Default sizes of the stores and the sample width
  localparam int unsigned SampleDepthDef = 2048;
  localparam int unsigned WeightDepthDef = 4096;
  localparam int unsigned MaxOutChDef    = 16;
  localparam int unsigned DataWidthDef   = 16;

  // Fixed-point fraction bits, store index width and output ceiling
  localparam int unsigned FracBits  = 12;
  localparam int unsigned IdxW      = 20;
  localparam int unsigned PooledMax = 32767;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_WEIGHT  = 2'd1,
    ACT_BIAS    = 2'd2,
    ACT_COMPUTE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_IN_ROWS     = 3'd0,
    REG_IN_COLS     = 3'd1,
    REG_IN_CHANNELS = 3'd2,
    REG_KERNEL_ROWS = 3'd3,
    REG_KERNEL_COLS = 3'd4,
    REG_POOL_SIZE   = 3'd5,
    REG_RELU_ENABLE = 3'd6,
    REG_BIAS_ENABLE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    action_e            action;
    logic [11:0]        address;
    logic signed [15:0] value;
    logic [3:0]         out_channel;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
  } in_item_t;

  typedef struct packed {
    logic [14:0] pooled_value;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [6:0] in_rows;
    logic [6:0] in_cols;
    logic [4:0] in_channels;
    logic [3:0] kernel_rows;
    logic [3:0] kernel_cols;
    logic [2:0] pool_size;
    logic       relu_enable;
    logic       bias_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    in_rows:     7'd32,
    in_cols:     7'd32,
    in_channels: 5'd1,
    kernel_rows: 4'd5,
    kernel_cols: 4'd5,
    pool_size:   3'd2,
    relu_enable: 1'b1,
    bias_enable: 1'b1
  };

  // Which kernel loop advances after a multiply-accumulate
  typedef enum logic [1:0] {
    STEP_CH  = 2'd0,
    STEP_KC  = 2'd1,
    STEP_KR  = 2'd2,
    STEP_END = 2'd3
  } mac_step_e;

  // Which pool loop advances after a position is finished
  typedef enum logic [1:0] {
    POS_COL  = 2'd0,
    POS_ROW  = 2'd1,
    POS_LAST = 2'd2
  } pos_step_e;

  typedef struct packed {
    logic      load;
    logic      capture;
    logic      setup1;
    logic      setup2;
    logic      mac;
    mac_step_e step;
    logic      fin1;
    logic      fin2;
    pos_step_e pos;
    logic      out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic oor;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/crm_dp.sv */
// Datapath: stores, address generation, MAC pipeline, bias/shift/saturate, pooling, output register.
`default_nettype none

module crm_dp #(
  parameter int unsigned SAMPLE_DEPTH     = crm_pkg::SampleDepthDef,
  parameter int unsigned WEIGHT_DEPTH     = crm_pkg::WeightDepthDef,
  parameter int unsigned MAX_OUT_CHANNELS = crm_pkg::MaxOutChDef,
  parameter int unsigned DATA_WIDTH       = crm_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crm_pkg::cfg_t      cfg_i,
  input  crm_pkg::in_item_t  in_data_i,
  input  crm_pkg::dp_cmd_t   cmd_i,
  output crm_pkg::dp_stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crm_pkg::out_item_t out_data_o
);

  localparam int unsigned IW    = crm_pkg::IdxW;
  localparam int unsigned SAW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned WAW   = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int unsigned BAW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam int unsigned AccW  = ProdW + crm_pkg::FracBits;
  localparam int unsigned ShW   = AccW + 1 - crm_pkg::FracBits;

  localparam logic signed [DATA_WIDTH-1:0] DataMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DataMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Stores
  logic signed [DATA_WIDTH-1:0] sample_mem [SAMPLE_DEPTH];
  logic signed [DATA_WIDTH-1:0] weight_mem [WEIGHT_DEPTH];
  logic signed [DATA_WIDTH-1:0] bias_mem   [MAX_OUT_CHANNELS];

  logic signed [DATA_WIDTH-1:0] wr_data;
  logic [IW-1:0]                wr_addr;

  // Request and setup registers
  logic [3:0]  oc_q;
  logic [4:0]  orow_q, ocol_q;
  logic [13:0] area_q;
  logic [7:0]  ksz_q;
  logic [8:0]  ocic_q;
  logic [7:0]  r0_q, c0_q;
  logic        oor_q;
  logic signed [DATA_WIDTH-1:0] bias_q;
  logic        bias_ok_q;
  logic [8:0]  aux_r, aux_c, rend, cend;
  logic        oor_d;
  logic [IW-1:0] bias_idx;

  // Address generation
  logic [IW-1:0] s_pibase_q, s_base_q, s_row_q, s_pos_q, ch_s_q;
  logic [IW-1:0] w_oc_q, ch_w_q, w_k_q;
  logic [IW-1:0] s_idx, w_idx, setup_base, pos_base;

  // MAC pipeline
  logic                         mac_v_q, prod_v_q, s_ok_q, w_ok_q;
  logic signed [DATA_WIDTH-1:0] s_rd_q, w_rd_q, s_op, w_op;
  logic signed [ProdW-1:0]      prod_q;
  logic signed [AccW-1:0]       acc_q;

  // Post-processing
  logic signed [AccW:0]         bsum;
  logic signed [DATA_WIDTH-1:0] bias_sel;
  logic signed [ShW-1:0]        sh_q;
  logic signed [DATA_WIDTH-1:0] sat, act;
  logic signed [DATA_WIDTH-1:0] best_q;
  logic [32:0]                  best_ext;
  logic [14:0]                  pooled;

  logic               out_valid_q;
  crm_pkg::out_item_t out_q;

  // Store writes from load items
  assign wr_data = DATA_WIDTH'(in_data_i.value);
  assign wr_addr = IW'(in_data_i.address);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_data_i.action == crm_pkg::ACT_SAMPLE &&
        wr_addr < IW'(SAMPLE_DEPTH)) begin
      sample_mem[wr_addr[SAW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_data_i.action == crm_pkg::ACT_WEIGHT &&
        wr_addr < IW'(WEIGHT_DEPTH)) begin
      weight_mem[wr_addr[WAW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_data_i.action == crm_pkg::ACT_BIAS &&
        wr_addr < IW'(MAX_OUT_CHANNELS)) begin
      bias_mem[wr_addr[BAW-1:0]] <= wr_data;
    end
  end

  // Capture the compute request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      oc_q   <= in_data_i.out_channel;
      orow_q <= in_data_i.out_row;
      ocol_q <= in_data_i.out_col;
    end
  end

  // Range check of the requested window
  assign aux_r = 9'(cfg_i.in_rows) - 9'(cfg_i.kernel_rows) + 9'd1;
  assign aux_c = 9'(cfg_i.in_cols) - 9'(cfg_i.kernel_cols) + 9'd1;
  assign rend  = (9'(orow_q) + 9'd1) * 9'(cfg_i.pool_size);
  assign cend  = (9'(ocol_q) + 9'd1) * 9'(cfg_i.pool_size);
  assign oor_d = (cfg_i.in_rows == '0) || (cfg_i.in_cols == '0) ||
                 (cfg_i.in_channels == '0) || (cfg_i.kernel_rows == '0) ||
                 (cfg_i.kernel_cols == '0) || (cfg_i.pool_size == '0) ||
                 (7'(cfg_i.kernel_rows) > cfg_i.in_rows) ||
                 (7'(cfg_i.kernel_cols) > cfg_i.in_cols) ||
                 (rend > aux_r) || (cend > aux_c);
  assign bias_idx = IW'(oc_q);

  // First setup cycle: layer products, range flag, bias read
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup1) begin
      area_q    <= 14'(cfg_i.in_rows) * 14'(cfg_i.in_cols);
      ksz_q     <= 8'(cfg_i.kernel_rows) * 8'(cfg_i.kernel_cols);
      ocic_q    <= 9'(oc_q) * 9'(cfg_i.in_channels);
      r0_q      <= 8'(orow_q) * 8'(cfg_i.pool_size);
      c0_q      <= 8'(ocol_q) * 8'(cfg_i.pool_size);
      oor_q     <= oor_d;
      bias_q    <= bias_mem[bias_idx[BAW-1:0]];
      bias_ok_q <= cfg_i.bias_enable && (9'(oc_q) < 9'(MAX_OUT_CHANNELS));
    end
  end

  // Address counters
  assign setup_base = IW'(r0_q) * IW'(cfg_i.in_cols) + IW'(c0_q);
  assign pos_base   = (cmd_i.pos == crm_pkg::POS_ROW) ? s_pibase_q + IW'(cfg_i.in_cols)
                                                      : s_base_q + IW'(1);
  assign s_idx = s_pos_q + ch_s_q;
  assign w_idx = w_oc_q + ch_w_q + w_k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup2) begin
      s_pibase_q <= setup_base;
      s_base_q   <= setup_base;
      s_row_q    <= setup_base;
      s_pos_q    <= setup_base;
      ch_s_q     <= '0;
      ch_w_q     <= '0;
      w_k_q      <= '0;
      w_oc_q     <= IW'(ocic_q) * IW'(ksz_q);
    end else if (cmd_i.mac) begin
      unique case (cmd_i.step)
        crm_pkg::STEP_CH: begin
          ch_s_q <= ch_s_q + IW'(area_q);
          ch_w_q <= ch_w_q + IW'(ksz_q);
        end
        crm_pkg::STEP_KC: begin
          ch_s_q  <= '0;
          ch_w_q  <= '0;
          s_pos_q <= s_pos_q + IW'(1);
          w_k_q   <= w_k_q + IW'(1);
        end
        crm_pkg::STEP_KR: begin
          ch_s_q  <= '0;
          ch_w_q  <= '0;
          s_row_q <= s_row_q + IW'(cfg_i.in_cols);
          s_pos_q <= s_row_q + IW'(cfg_i.in_cols);
          w_k_q   <= w_k_q + IW'(1);
        end
        crm_pkg::STEP_END: begin
        end
      endcase
    end else if (cmd_i.fin2 && cmd_i.pos != crm_pkg::POS_LAST) begin
      if (cmd_i.pos == crm_pkg::POS_ROW) begin
        s_pibase_q <= pos_base;
      end
      s_base_q <= pos_base;
      s_row_q  <= pos_base;
      s_pos_q  <= pos_base;
      ch_s_q   <= '0;
      ch_w_q   <= '0;
      w_k_q    <= '0;
    end
  end

  // Store reads, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) begin
      s_rd_q <= sample_mem[s_idx[SAW-1:0]];
      w_rd_q <= weight_mem[w_idx[WAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      s_ok_q   <= 1'b0;
      w_ok_q   <= 1'b0;
    end else begin
      mac_v_q  <= cmd_i.mac;
      prod_v_q <= mac_v_q;
      s_ok_q   <= s_idx < IW'(SAMPLE_DEPTH);
      w_ok_q   <= w_idx < IW'(WEIGHT_DEPTH);
    end
  end

  // Multiply, then accumulate
  assign s_op = s_ok_q ? s_rd_q : '0;
  assign w_op = w_ok_q ? w_rd_q : '0;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(s_op) * ProdW'(w_op);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup2 || cmd_i.fin1) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // Add bias and drop the fraction, rounding toward minus infinity
  assign bias_sel = bias_ok_q ? bias_q : '0;
  assign bsum     = (AccW+1)'(acc_q) + ((AccW+1)'(bias_sel) <<< crm_pkg::FracBits);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin1) begin
      sh_q <= ShW'(bsum >>> crm_pkg::FracBits);
    end
  end

  // Saturate, ReLU, pool
  always_comb begin
    if (sh_q > ShW'(DataMax)) begin
      sat = DataMax;
    end else if (sh_q < ShW'(DataMin)) begin
      sat = DataMin;
    end else begin
      sat = DATA_WIDTH'(sh_q);
    end
    act = (cfg_i.relu_enable && sat < 0) ? '0 : sat;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup2) begin
      best_q <= '0;
    end else if (cmd_i.fin2 && act > best_q) begin
      best_q <= act;
    end
  end

  assign best_ext = 33'($unsigned(best_q));
  assign pooled   = (best_ext > 33'(crm_pkg::PooledMax)) ? 15'(crm_pkg::PooledMax)
                                                         : 15'(best_ext);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_write) begin
      out_q.pooled_value <= oor_q ? '0 : pooled;
      out_q.out_of_range <= oor_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.oor      = oor_q;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

/* rtl/crm_ctrl.sv */
// Controller: input handshake, loop counters and sequencing of the datapath.
`default_nettype none

module crm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crm_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  input  crm_pkg::action_e   in_action_i,
  output logic               in_stall_o,
  input  crm_pkg::dp_stat_t  stat_i,
  output crm_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SETUP1 = 8'b0000_0010,
    ST_SETUP2 = 8'b0000_0100,
    ST_RUN    = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_FIN1   = 8'b0010_0000,
    ST_FIN2   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] ch_q;
  logic [3:0] kc_q, kr_q;
  logic [2:0] pj_q, pi_q;
  logic       drain_q;
  logic       accept, last_ch, last_kc, last_kr, last_pj, last_pi;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = !(state_q == ST_IDLE);

  assign last_ch = (ch_q + 5'd1) == cfg_i.in_channels;
  assign last_kc = (kc_q + 4'd1) == cfg_i.kernel_cols;
  assign last_kr = (kr_q + 4'd1) == cfg_i.kernel_rows;
  assign last_pj = (pj_q + 3'd1) == cfg_i.pool_size;
  assign last_pi = (pi_q + 3'd1) == cfg_i.pool_size;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.step = crm_pkg::STEP_END;
    cmd_o.pos  = crm_pkg::POS_LAST;
    cmd_o.load    = accept && (in_action_i != crm_pkg::ACT_COMPUTE);
    cmd_o.capture = accept && (in_action_i == crm_pkg::ACT_COMPUTE);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_SETUP1;
        end
      end
      ST_SETUP1: begin
        cmd_o.setup1 = 1'b1;
        state_d      = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd_o.setup2 = 1'b1;
        state_d      = stat_i.oor ? ST_OUT : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.mac = 1'b1;
        priority if (!last_ch) begin
          cmd_o.step = crm_pkg::STEP_CH;
        end else if (!last_kc) begin
          cmd_o.step = crm_pkg::STEP_KC;
        end else if (!last_kr) begin
          cmd_o.step = crm_pkg::STEP_KR;
        end else begin
          cmd_o.step = crm_pkg::STEP_END;
          state_d    = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_FIN1;
        end
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        priority if (!last_pj) begin
          cmd_o.pos = crm_pkg::POS_COL;
          state_d   = ST_RUN;
        end else if (!last_pi) begin
          cmd_o.pos = crm_pkg::POS_ROW;
          state_d   = ST_RUN;
        end else begin
          cmd_o.pos = crm_pkg::POS_LAST;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_write = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      kc_q    <= '0;
      kr_q    <= '0;
      pj_q    <= '0;
      pi_q    <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= (state_q == ST_DRAIN) && !drain_q;
      if (cmd_o.setup2) begin
        ch_q <= '0;
        kc_q <= '0;
        kr_q <= '0;
        pj_q <= '0;
        pi_q <= '0;
      end else if (cmd_o.mac) begin
        unique case (cmd_o.step)
          crm_pkg::STEP_CH: ch_q <= ch_q + 5'd1;
          crm_pkg::STEP_KC: begin
            ch_q <= '0;
            kc_q <= kc_q + 4'd1;
          end
          crm_pkg::STEP_KR: begin
            ch_q <= '0;
            kc_q <= '0;
            kr_q <= kr_q + 4'd1;
          end
          crm_pkg::STEP_END: begin
            ch_q <= '0;
            kc_q <= '0;
            kr_q <= '0;
          end
        endcase
      end else if (cmd_o.fin2) begin
        if (cmd_o.pos == crm_pkg::POS_COL) begin
          pj_q <= pj_q + 3'd1;
        end else if (cmd_o.pos == crm_pkg::POS_ROW) begin
          pj_q <= '0;
          pi_q <= pi_q + 3'd1;
        end
      end
    end
  end

  // The output register is free whenever a result is written into it
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_write |-> !stat_i.out_busy)
    else $error("result written while output register is held");

  // Kernel counters stay inside the configured window while MACs issue
  a_kernel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (ch_q < cfg_i.in_channels) && (kc_q < cfg_i.kernel_cols) &&
                            (kr_q < cfg_i.kernel_rows))
    else $error("kernel counter out of range");

  // Pool counters stay inside the pool window
  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN2) |-> (pi_q < cfg_i.pool_size) && (pj_q < cfg_i.pool_size))
    else $error("pool counter out of range");

  // Every pooled position is finalized once the DRAIN state has drained the MAC pipeline after its last MAC
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mac && cmd_o.step == crm_pkg::STEP_END) |-> ##3 (state_q == ST_FIN1))
    else $error("finalize not aligned with accumulator drain");

endmodule

`default_nettype wire

/* rtl/conv2d_relu_maxpool.sv */
// Top level: configuration registers, controller and datapath of the fused conv/ReLU/max-pool layer.
`default_nettype none

// Load items (sample, weight, bias) are written into their store as they are
// accepted, and the block stays ready for the next item. A compute item passes
// the setup states and then, for each of the P*P pooled positions, where P is
// pool_size, C in_channels and KR, KC the kernel size, issues C*KR*KC MACs, one
// MAC per cycle through the single sample and weight read ports, then drains the
// MAC pipeline to add the bias, saturate, apply ReLU and take the maximum. A
// request whose window leaves the map goes from the setup states straight to the
// output register. One compute item is in work at a time; the result sits in an
// output register, so the next item is taken while it waits. The stores hold no
// reset value: read only entries that were written.

module conv2d_relu_maxpool #(
  parameter int unsigned SAMPLE_DEPTH     = crm_pkg::SampleDepthDef,
  parameter int unsigned WEIGHT_DEPTH     = crm_pkg::WeightDepthDef,
  parameter int unsigned MAX_OUT_CHANNELS = crm_pkg::MaxOutChDef,
  parameter int unsigned DATA_WIDTH       = crm_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  crm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crm_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  crm_pkg::cfg_t     cfg_q;
  crm_pkg::dp_cmd_t  cmd;
  crm_pkg::dp_stat_t stat;
  crm_pkg::reg_idx_e reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = crm_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= crm_pkg::CfgReset;
    end else if (cfg_write) begin
      unique case (reg_idx)
        crm_pkg::REG_IN_ROWS:     cfg_q.in_rows     <= pwdata[6:0];
        crm_pkg::REG_IN_COLS:     cfg_q.in_cols     <= pwdata[6:0];
        crm_pkg::REG_IN_CHANNELS: cfg_q.in_channels <= pwdata[4:0];
        crm_pkg::REG_KERNEL_ROWS: cfg_q.kernel_rows <= pwdata[3:0];
        crm_pkg::REG_KERNEL_COLS: cfg_q.kernel_cols <= pwdata[3:0];
        crm_pkg::REG_POOL_SIZE:   cfg_q.pool_size   <= pwdata[2:0];
        crm_pkg::REG_RELU_ENABLE: cfg_q.relu_enable <= pwdata[0];
        crm_pkg::REG_BIAS_ENABLE: cfg_q.bias_enable <= pwdata[0];
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      crm_pkg::REG_IN_ROWS:     prdata = 32'(cfg_q.in_rows);
      crm_pkg::REG_IN_COLS:     prdata = 32'(cfg_q.in_cols);
      crm_pkg::REG_IN_CHANNELS: prdata = 32'(cfg_q.in_channels);
      crm_pkg::REG_KERNEL_ROWS: prdata = 32'(cfg_q.kernel_rows);
      crm_pkg::REG_KERNEL_COLS: prdata = 32'(cfg_q.kernel_cols);
      crm_pkg::REG_POOL_SIZE:   prdata = 32'(cfg_q.pool_size);
      crm_pkg::REG_RELU_ENABLE: prdata = 32'(cfg_q.relu_enable);
      crm_pkg::REG_BIAS_ENABLE: prdata = 32'(cfg_q.bias_enable);
    endcase
  end

  crm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crm_dp #(
    .SAMPLE_DEPTH     (SAMPLE_DEPTH),
    .WEIGHT_DEPTH     (WEIGHT_DEPTH),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .DATA_WIDTH       (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* bench/tb_conv2d_relu_maxpool.sv */
// Self-checking bench for the fused conv/ReLU/max-pool layer: queued driver, monitor, predictor.
`default_nettype none

module tb_conv2d_relu_maxpool;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FillDepth = 128;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  crm_pkg::in_item_t    in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  crm_pkg::out_item_t   out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [4:0]           paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  conv2d_relu_maxpool dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // Shadow layer shape and store contents
  crm_pkg::cfg_t      layer_cfg = crm_pkg::CfgReset;
  logic signed [15:0] sample_mem [crm_pkg::SampleDepthDef];
  logic signed [15:0] weight_mem [crm_pkg::WeightDepthDef];
  logic signed [15:0] bias_mem   [crm_pkg::MaxOutChDef];

  crm_pkg::in_item_t  pending_q[$];
  crm_pkg::out_item_t pooled_q[$];
  bit                 check_q[$];
  int        err_cnt     = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        tx_pause    = 1'b0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;
  int        hold_cnt    = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Apply one item to the shadow stores; return 1 with the pooled result for a compute.
  // known drops to 0 when the compute reads a store entry that was never written.
  function automatic bit predict_pool(input crm_pkg::in_item_t it,
                                      output crm_pkg::out_item_t res, output bit known);
    int unsigned     rows, cols, chs, krs, kcs, ps, aux_r, aux_c;
    longint          acc, s, best, bias, sv, wv;
    longint unsigned si, wi, area, r0, c0;
    res   = '{pooled_value: '0, out_of_range: 1'b1};
    known = 1'b1;
    case (it.action)
      crm_pkg::ACT_SAMPLE: begin
        if (it.address < crm_pkg::SampleDepthDef) sample_mem[it.address] = it.value;
        return 1'b0;
      end
      crm_pkg::ACT_WEIGHT: begin
        if (it.address < crm_pkg::WeightDepthDef) weight_mem[it.address] = it.value;
        return 1'b0;
      end
      crm_pkg::ACT_BIAS: begin
        if (it.address < crm_pkg::MaxOutChDef) bias_mem[it.address] = it.value;
        return 1'b0;
      end
      default: ;
    endcase
    rows = 32'(layer_cfg.in_rows);     cols = 32'(layer_cfg.in_cols);
    chs  = 32'(layer_cfg.in_channels); ps   = 32'(layer_cfg.pool_size);
    krs  = 32'(layer_cfg.kernel_rows); kcs  = 32'(layer_cfg.kernel_cols);
    if (rows == 0 || cols == 0 || chs == 0 || krs == 0 || kcs == 0 || ps == 0 ||
        krs > rows || kcs > cols) return 1'b1;
    aux_r = rows - krs + 1;
    aux_c = cols - kcs + 1;
    if (32'(it.out_row) >= aux_r / ps || 32'(it.out_col) >= aux_c / ps) return 1'b1;
    bias = 0;
    if (layer_cfg.bias_enable) begin
      if ($isunknown(bias_mem[it.out_channel])) known = 1'b0;
      else bias = longint'(bias_mem[it.out_channel]);
    end
    area = rows * cols;
    best = 0;
    for (int pi = 0; pi < ps; pi++) begin
      for (int pj = 0; pj < ps; pj++) begin
        acc = 0;
        r0  = 32'(it.out_row) * ps + pi;
        c0  = 32'(it.out_col) * ps + pj;
        for (int kr = 0; kr < krs; kr++)
          for (int kc = 0; kc < kcs; kc++)
            for (int ch = 0; ch < chs; ch++) begin
              si = ch * area + (r0 + kr) * cols + (c0 + kc);
              wi = ((32'(it.out_channel) * chs + ch) * krs + kr) * kcs + kc;
              sv = 0;
              wv = 0;
              if (si < crm_pkg::SampleDepthDef) begin
                if ($isunknown(sample_mem[si])) known = 1'b0;
                else sv = longint'(sample_mem[si]);
              end
              if (wi < crm_pkg::WeightDepthDef) begin
                if ($isunknown(weight_mem[wi])) known = 1'b0;
                else wv = longint'(weight_mem[wi]);
              end
              acc += sv * wv;
            end
        acc += bias * 4096;
        s = acc >>> crm_pkg::FracBits;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        if (layer_cfg.relu_enable && s < 0) s = 0;
        if (s > best) best = s;
      end
    end
    if (best > crm_pkg::PooledMax) best = crm_pkg::PooledMax;
    res.pooled_value = best[14:0];
    res.out_of_range = 1'b0;
    return 1'b1;
  endfunction

  // Offer queued items; predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic               nv;
    crm_pkg::in_item_t  nd;
    crm_pkg::out_item_t r;
    bit                 k;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      nv = in_valid_i;
      nd = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        if (predict_pool(in_data_i, r, k)) begin
          pooled_q.push_back(r);
          check_q.push_back(k);
        end
        void'(pending_q.pop_front());
        nv = 1'b0;
      end
      if (!nv && pending_q.size() != 0 && !tx_pause &&
          $urandom_range(99) >= tx_idle_pct) begin
        nv = 1'b1;
        nd = pending_q[0];
      end
      in_valid_i <= nv;
      in_data_i  <= nd;
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_req && !hold_done) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end
  end

  // Check accepted results against the oldest expectation; stall at random
  always @(posedge clk_i or negedge rst_ni) begin : mon
    crm_pkg::out_item_t e;
    bit                 chk;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pooled_q.size() == 0) begin
          report_mismatch("result with no expectation");
        end else begin
          e   = pooled_q.pop_front();
          chk = check_q.pop_front();
          if (chk && out_data_o.pooled_value !== e.pooled_value)
            report_mismatch($sformatf("pooled_value got %0d exp %0d",
                                      out_data_o.pooled_value, e.pooled_value));
          if (out_data_o.out_of_range !== e.out_of_range)
            report_mismatch($sformatf("out_of_range got %0b exp %0b",
                                      out_data_o.out_of_range, e.out_of_range));
        end
      end
      out_stall_i <= (hold_cnt != 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || pooled_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input crm_pkg::reg_idx_e idx, input int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      crm_pkg::REG_IN_ROWS:     layer_cfg.in_rows     = val[6:0];
      crm_pkg::REG_IN_COLS:     layer_cfg.in_cols     = val[6:0];
      crm_pkg::REG_IN_CHANNELS: layer_cfg.in_channels = val[4:0];
      crm_pkg::REG_KERNEL_ROWS: layer_cfg.kernel_rows = val[3:0];
      crm_pkg::REG_KERNEL_COLS: layer_cfg.kernel_cols = val[3:0];
      crm_pkg::REG_POOL_SIZE:   layer_cfg.pool_size   = val[2:0];
      crm_pkg::REG_RELU_ENABLE: layer_cfg.relu_enable = val[0];
      default:                  layer_cfg.bias_enable = val[0];
    endcase
  endtask

  task automatic set_layer(input int unsigned rows, cols, chs, krs, kcs, ps, relu, bias);
    wait_idle();
    write_reg(crm_pkg::REG_IN_ROWS, rows);
    write_reg(crm_pkg::REG_IN_COLS, cols);
    write_reg(crm_pkg::REG_IN_CHANNELS, chs);
    write_reg(crm_pkg::REG_KERNEL_ROWS, krs);
    write_reg(crm_pkg::REG_KERNEL_COLS, kcs);
    write_reg(crm_pkg::REG_POOL_SIZE, ps);
    write_reg(crm_pkg::REG_RELU_ENABLE, relu);
    write_reg(crm_pkg::REG_BIAS_ENABLE, bias);
  endtask

  function automatic crm_pkg::in_item_t mk_item(input crm_pkg::action_e act,
                                                input int unsigned addr, input int val,
                                                input int unsigned oc, r, c);
    crm_pkg::in_item_t it;
    it.action      = act;
    it.address     = addr[11:0];
    it.value       = val[15:0];
    it.out_channel = oc[3:0];
    it.out_row     = r[4:0];
    it.out_col     = c[4:0];
    return it;
  endfunction

  function automatic int rand_value();
    if ($urandom_range(3) == 0) return int'($urandom_range(65535));
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // Mostly loads inside the live map and computes inside the pooled grid, some noise
  function automatic crm_pkg::in_item_t rand_item();
    crm_pkg::in_item_t it;
    int unsigned       pr, pc, span;
    it = crm_pkg::in_item_t'($bits(crm_pkg::in_item_t)'({$urandom(), $urandom()}));
    span = 32'(layer_cfg.in_rows) * 32'(layer_cfg.in_cols) * 32'(layer_cfg.in_channels);
    case ($urandom_range(9))
      0, 1: begin
        it.action  = crm_pkg::ACT_SAMPLE;
        it.address = (span != 0 && $urandom_range(4) != 0) ?
                     12'($urandom_range(span - 1)) : 12'($urandom_range(4095));
        it.value   = 16'(rand_value());
      end
      2, 3: begin
        it.action = crm_pkg::ACT_WEIGHT;
        if ($urandom_range(4) != 0) it.address = 12'($urandom_range(255));
        it.value  = 16'(rand_value());
      end
      4: begin
        it.action = crm_pkg::ACT_BIAS;
        if ($urandom_range(3) != 0) it.address = 12'($urandom_range(15));
        it.value  = 16'(rand_value());
      end
      default: begin
        it.action = crm_pkg::ACT_COMPUTE;
        if ($urandom_range(3) != 0) it.out_channel = 4'($urandom_range(3));
        pr = 1;
        pc = 1;
        if (layer_cfg.pool_size != 0 && layer_cfg.kernel_rows <= layer_cfg.in_rows &&
            layer_cfg.kernel_cols <= layer_cfg.in_cols) begin
          pr = (32'(layer_cfg.in_rows) - 32'(layer_cfg.kernel_rows) + 1) /
               32'(layer_cfg.pool_size);
          pc = (32'(layer_cfg.in_cols) - 32'(layer_cfg.kernel_cols) + 1) /
               32'(layer_cfg.pool_size);
        end
        if ($urandom_range(5) != 0 && pr != 0 && pc != 0) begin
          it.out_row = 5'($urandom_range((pr > 32 ? 32 : pr) - 1));
          it.out_col = 5'($urandom_range((pc > 32 ? 32 : pc) - 1));
        end
      end
    endcase
    return it;
  endfunction

  // Main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low store entries that the small random shapes read
    for (int i = 0; i < FillDepth; i++)
      pending_q.push_back(mk_item(crm_pkg::ACT_SAMPLE, i, rand_value(), 0, 0, 0));
    for (int i = 0; i < FillDepth; i++)
      pending_q.push_back(mk_item(crm_pkg::ACT_WEIGHT, i, rand_value(), 0, 0, 0));
    for (int i = 0; i < crm_pkg::MaxOutChDef; i++)
      pending_q.push_back(mk_item(crm_pkg::ACT_BIAS, i, rand_value(), 0, 0, 0));
    wait_idle();

    // Directed: field extremes, ignored loads, grid edges at the reset shape
    pending_q.push_back(mk_item(crm_pkg::ACT_SAMPLE, 0, 32767, 15, 31, 31));
    pending_q.push_back(mk_item(crm_pkg::ACT_SAMPLE, 1, -32768, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_SAMPLE, 4095, 1234, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_WEIGHT, 0, 32767, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_WEIGHT, 1, -32768, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_WEIGHT, 4095, -1, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_BIAS, 15, -32768, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_BIAS, 0, 32767, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_BIAS, 4095, 77, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 4095, -1, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 15, 13, 13));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 15, 14, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 3, 0, 14));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 31, 31));
    set_layer(0, 32, 1, 5, 5, 2, 1, 1);     // zero dimension
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0));
    set_layer(4, 4, 1, 5, 5, 2, 1, 1);      // kernel larger than the map
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0));
    set_layer(1, 1, 1, 1, 1, 1, 0, 0);      // smallest shape, no ReLU, no bias
    pending_q.push_back(mk_item(crm_pkg::ACT_SAMPLE, 0, -5000, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 0, 1));
    set_layer(64, 64, 16, 8, 8, 4, 1, 1);   // largest directed shape
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 15, 13, 13));
    pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, 0, 14, 0));

    // Random phases over varied layer shapes and idle mixes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 3)      set_layer(64, 64, 16, 8, 8, 4, 1, 1);
      else if (ph == 5) set_layer(20, 20, 0, 3, 3, 2, 1, 1);
      else if (ph == 7) set_layer(3, 9, 2, 4, 2, 1, 0, 1);
      else if (ph == 10) set_layer(127, 127, 31, 15, 15, 7, 0, 0);
      else set_layer($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 2),
                     $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2),
                     $urandom_range(1), $urandom_range(1));
      tx_idle_pct = (ph < 4) ? 21 : (ph < 8) ? 62 : 0;
      rx_idle_pct = (ph < 4) ? 62 : (ph < 8) ? 21 : 0;
      if (ph == 3 || ph == 10) begin
        for (int i = 0; i < 4; i++)
          pending_q.push_back(mk_item(crm_pkg::ACT_COMPUTE, 0, 0, $urandom_range(15), i, i));
        continue;
      end
      for (int i = 0; i < 20; i++) pending_q.push_back(rand_item());
      if (ph == 1) hold_req = 1'b1;
      if (ph == 9) begin
        // Pause the sender until every result is back
        tx_pause = 1'b1;
        while (pooled_q.size() != 0 || in_valid_i) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
        tx_pause = 1'b0;
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && pooled_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard limit on run length
  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
